// ----- rtl/max_heap_priority_queue_defines.svh -----
// Assertion macros shared by the heap queue modules.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MHPQ_ASSERT_IMPL(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");
`define MHPQ_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define MHPQ_ASSERT_IMPL(lbl, ck, rn, a, c)
`define MHPQ_ASSERT_NEXT(lbl, ck, rn, a, c)
`endif

`endif

// ----- rtl/mhpq_pkg.sv -----
package mhpq_pkg;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 8;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [1:0]              status_t;
	typedef logic [2:0]              rd_sel_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam status_t ST_INSERTED     = 2'd0;
	localparam status_t ST_REMOVED      = 2'd1;
	localparam status_t ST_FULL_REFUSED = 2'd2;
	localparam status_t ST_EMPTY_REFUSED = 2'd3;

	localparam rd_sel_t RD_NONE       = 3'd0;
	localparam rd_sel_t RD_ROOT       = 3'd1;
	localparam rd_sel_t RD_INS_PARENT = 3'd2;
	localparam rd_sel_t RD_GRAND      = 3'd3;
	localparam rd_sel_t RD_LAST       = 3'd4;
	localparam rd_sel_t RD_LEFT       = 3'd5;
	localparam rd_sel_t RD_RIGHT      = 3'd6;

	typedef struct packed {
		logic    latch_in;
		logic    start_ins;
		logic    capture_top;
		logic    capture_last;
		logic    capture_left;
		logic    move_up;
		logic    move_down;
		logic    use_right;
		logic    write_key;
		logic    set_status;
		status_t status_code;
		rd_sel_t rd_sel;
		logic    load_out;
	} mhpq_cmd_t;

	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic up_gt;
		logic up_next_root;
		logic kid_in;
		logic has_right;
		logic dn_gt;
	} mhpq_stat_t;

endpackage

// ----- rtl/max_heap_priority_queue.sv -----
// channel  handshake            payload
// req      req_valid/req_stall  op, key
// rsp      rsp_valid/rsp_stall  max_key, status, count
//
// Insert: the parent is read after accept, and each level climbed reads one further parent; remove:
// the root and the last element are read, then the left and, where present, the right child for each
// level descended (at most 7 levels at CAPACITY 255), all through the single read port of the heap
// memory; a new request can be accepted in the cycle after the result is loaded. Reset clears the
// count and the state machine; heap memory is not cleared. A new transaction is taken while a result
// waits in the output register. A stalled result only holds the block once the next result is ready to load.
module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               op,
	input  key_t               key,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output key_t               max_key,
	output status_t            status,
	output logic [COUNT_W-1:0] count
);

	mhpq_cmd_t  cmd;
	mhpq_stat_t stat;

	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mhpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.op      (op),
		.key     (key),
		.max_key (max_key),
		.status  (status),
		.count   (count)
	);

endmodule

// ----- rtl/mhpq_dp.sv -----
`include "max_heap_priority_queue_defines.svh"

module mhpq_dp
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_cmd_t           cmd,
	output mhpq_stat_t          stat,
	input  logic                op,
	input  key_t                key,
	output key_t                max_key,
	output status_t             status,
	output logic [COUNT_W-1:0]  count
);

	localparam int AW    = (CAPACITY < 2) ? 2 : $clog2(CAPACITY + 1);
	localparam int DEPTH = CAPACITY + 1;

	key_t            mem [DEPTH];
	key_t            rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	key_t            wr_data;

	logic            op_q;
	key_t            key_q;
	key_t            top_q;
	key_t            left_q;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   pos_q;
	status_t         res_status_q;
	key_t            max_key_q;
	status_t         status_q;
	logic [COUNT_W-1:0] count_q;

	logic [AW-1:0]   cnt_inc;
	logic [AW:0]     kid_w;
	logic [AW:0]     cnt_ext;
	logic [AW-1:0]   left_idx;
	logic [AW-1:0]   right_idx;
	logic            right_gt;
	key_t            child_val;
	logic [AW-1:0]   child_idx;
	logic [AW+COUNT_W-1:0] cnt_wide;

	assign cnt_inc   = cnt_q + AW'(1);
	assign kid_w     = {pos_q, 1'b0};
	assign cnt_ext   = {1'b0, cnt_q};
	assign left_idx  = kid_w[AW-1:0];
	assign right_idx = {pos_q[AW-2+1-1:0], 1'b1} ;
	assign right_gt  = rd_data_q > left_q;
	assign cnt_wide  = {{COUNT_W{1'b0}}, cnt_q};

	always_comb begin
		if (cmd.use_right && right_gt) begin
			child_val = rd_data_q;
			child_idx = right_idx;
		end else if (cmd.use_right) begin
			child_val = left_q;
			child_idx = left_idx;
		end else begin
			child_val = rd_data_q;
			child_idx = left_idx;
		end
	end

	always_comb begin
		rd_en   = cmd.rd_sel != RD_NONE;
		rd_addr = '0;
		unique case (cmd.rd_sel)
			RD_ROOT:       rd_addr = AW'(1);
			RD_INS_PARENT: rd_addr = cnt_inc >> 1;
			RD_GRAND:      rd_addr = pos_q >> 2;
			RD_LAST:       rd_addr = cnt_q;
			RD_LEFT:       rd_addr = left_idx;
			RD_RIGHT:      rd_addr = right_idx;
			default:       rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en   = cmd.move_up || cmd.move_down || cmd.write_key;
		wr_addr = pos_q;
		priority if (cmd.move_up) begin
			wr_data = rd_data_q;
		end else if (cmd.move_down) begin
			wr_data = child_val;
		end else begin
			wr_data = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_ins) begin
			cnt_q <= cnt_inc;
		end else if (cmd.capture_last) begin
			cnt_q <= cnt_q - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= op;
			key_q <= key;
		end else if (cmd.capture_last) begin
			key_q <= rd_data_q;
		end
		if (cmd.start_ins) begin
			pos_q <= cnt_inc;
		end else if (cmd.capture_last) begin
			pos_q <= AW'(1);
		end else if (cmd.move_up) begin
			pos_q <= pos_q >> 1;
		end else if (cmd.move_down) begin
			pos_q <= child_idx;
		end
		if (cmd.capture_top) begin
			top_q <= rd_data_q;
		end
		if (cmd.capture_left) begin
			left_q <= rd_data_q;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status_code;
		end
		if (cmd.load_out) begin
			max_key_q <= (res_status_q == ST_REMOVED) ? top_q : '0;
			status_q  <= res_status_q;
			count_q   <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign stat.op           = op_q;
	assign stat.full         = cnt_q == AW'(CAPACITY);
	assign stat.empty        = cnt_q == '0;
	assign stat.up_gt        = key_q > rd_data_q;
	assign stat.up_next_root = (pos_q >> 1) == AW'(1);
	assign stat.kid_in       = kid_w <= cnt_ext;
	assign stat.has_right    = kid_w < cnt_ext;
	assign stat.dn_gt        = child_val > key_q;

	assign max_key = max_key_q;
	assign status  = status_q;
	assign count   = count_q;

	`MHPQ_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= AW'(CAPACITY))
	`MHPQ_ASSERT_IMPL(a_wr_not_zero, clk, arst_n, wr_en, wr_addr != '0)
	`MHPQ_ASSERT_IMPL(a_up_only_gt, clk, arst_n, cmd.move_up, key_q > rd_data_q)

endmodule

// ----- rtl/mhpq_ctrl.sv -----
`include "max_heap_priority_queue_defines.svh"

module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  mhpq_stat_t stat,
	output mhpq_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_UP     = 4'd2;
	localparam logic [3:0] S_TOP    = 4'd3;
	localparam logic [3:0] S_LAST   = 4'd4;
	localparam logic [3:0] S_DN_CHK = 4'd5;
	localparam logic [3:0] S_DN_L   = 4'd6;
	localparam logic [3:0] S_DN_R   = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rsp_valid_q;
	logic       accept;
	logic       slot_free;

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.latch_in = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				if (stat.op == OP_INSERT) begin
					if (stat.full) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_FULL_REFUSED;
						state_d         = S_DONE;
					end else if (stat.empty) begin
						cmd.start_ins = 1'b1;
						state_d       = S_WRITE;
					end else begin
						cmd.start_ins = 1'b1;
						cmd.rd_sel    = RD_INS_PARENT;
						state_d       = S_UP;
					end
				end else begin
					if (stat.empty) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_EMPTY_REFUSED;
						state_d         = S_DONE;
					end else begin
						cmd.rd_sel = RD_ROOT;
						state_d    = S_TOP;
					end
				end
			end
			S_UP: begin
				if (stat.up_gt) begin
					cmd.move_up = 1'b1;
					if (stat.up_next_root) begin
						state_d = S_WRITE;
					end else begin
						cmd.rd_sel = RD_GRAND;
					end
				end else begin
					state_d = S_WRITE;
				end
			end
			S_TOP: begin
				cmd.capture_top = 1'b1;
				cmd.rd_sel      = RD_LAST;
				state_d         = S_LAST;
			end
			S_LAST: begin
				cmd.capture_last = 1'b1;
				state_d          = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (stat.kid_in) begin
					cmd.rd_sel = RD_LEFT;
					state_d    = S_DN_L;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DN_L: begin
				cmd.capture_left = 1'b1;
				if (stat.has_right) begin
					cmd.rd_sel = RD_RIGHT;
					state_d    = S_DN_R;
				end else if (stat.dn_gt) begin
					cmd.move_down = 1'b1;
					state_d       = S_DN_CHK;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DN_R: begin
				cmd.use_right = 1'b1;
				if (stat.dn_gt) begin
					cmd.move_down = 1'b1;
					state_d       = S_DN_CHK;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write_key   = 1'b1;
				cmd.set_status  = 1'b1;
				cmd.status_code = (stat.op == OP_INSERT) ? ST_INSERTED : ST_REMOVED;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`MHPQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, req_stall)
	`MHPQ_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load_out, !rsp_valid_q || !rsp_stall)
	`MHPQ_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, rsp_valid_q && !req_stall)

endmodule
